// File: sv/pst_pkg.sv
package pst_pkg;

   localparam int SlotCountDefault = 16;
   localparam int NormWidth = 17;

   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_PUSH_TOP    = 3'd1,
      ACT_POP_TOP     = 3'd2,
      ACT_PUSH_BOTTOM = 3'd3,
      ACT_POP_BOTTOM  = 3'd4,
      ACT_CLEAR_ALL   = 3'd5
   } act_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
   } point_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] coord_x;
      logic signed [15:0] coord_y;
      logic signed [15:0] coord_z;
   } req_type;

   typedef struct packed {
      logic [4:0]         used_count;
      logic               dropped;
      logic [3:0]         far_slot;
      logic signed [15:0] far_x;
      logic signed [15:0] far_y;
      logic signed [15:0] far_z;
      logic [3:0]         near_slot;
      logic signed [15:0] near_x;
      logic signed [15:0] near_y;
      logic signed [15:0] near_z;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic issue;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_last;
      logic rsp_busy;
   } status_type;

   function automatic logic [NormWidth-1:0] mag16(input logic signed [15:0] v);
      logic signed [16:0] e;
      e = {v[15], v};
      return e[16] ? NormWidth'(-e) : NormWidth'(e);
   endfunction

   function automatic logic [NormWidth-1:0] l1_norm(input logic signed [15:0] x,
                                                    input logic signed [15:0] y,
                                                    input logic signed [15:0] z);
      return NormWidth'(mag16(x) + mag16(y) + mag16(z));
   endfunction

endpackage

// File: sv/pst_ctrl.sv
module pst_ctrl
   import pst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!status.rsp_busy) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            cmd.out_load = !status.rsp_busy;
         end
         default: begin
         end
      endcase
   end

endmodule

// File: sv/pst_dp.sv
module pst_dp
   import pst_pkg::*;
#(
   parameter int SLOT_COUNT = SlotCountDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   localparam int IW  = $clog2(SLOT_COUNT);
   localparam int IW1 = IW + 1;
   localparam int CW  = $clog2(SLOT_COUNT + 1);
   localparam logic [IW-1:0] LastIdx  = IW'(SLOT_COUNT - 1);
   localparam logic [IW:0]   SlotsExt = IW1'(SLOT_COUNT);

   function automatic logic [IW-1:0] phys(input logic [IW-1:0] b, input logic [IW-1:0] i);
      logic [IW:0] s;
      s = {1'b0, b} + {1'b0, i};
      if (s >= SlotsExt) s = s - SlotsExt;
      return s[IW-1:0];
   endfunction

   point_type mem [SLOT_COUNT];

   logic [SLOT_COUNT-1:0] used_ff;
   logic [IW-1:0]         base_ff;
   logic [IW-1:0]         idx_ff;
   logic [2:0]            act_ff;
   point_type             pt_ff;
   logic                  up_ff;
   logic                  done_ff;
   logic                  drop_ff;
   logic                  eval_vld_ff;
   logic [IW-1:0]         eval_idx_ff;
   point_type             rd_ff;
   logic [CW-1:0]         cnt_ff;
   logic                  any_ff;
   logic [NormWidth-1:0]  far_n_ff;
   logic [NormWidth-1:0]  near_n_ff;
   logic [IW-1:0]         far_idx_ff;
   logic [IW-1:0]         near_idx_ff;
   point_type             far_pt_ff;
   point_type             near_pt_ff;
   rsp_type               rsp_ff;
   logic                  rsp_vld_ff;

   logic [IW-1:0]        base_dec;
   point_type            req_pt;
   logic                 req_up;
   logic                 ev_used;
   logic                 claim_push;
   logic                 claim_pop;
   logic                 eff_used;
   point_type            eff_pt;
   logic [NormWidth-1:0] norm;
   logic                 far_take;
   logic                 near_take;
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   point_type            wr_data;
   logic [IW-1:0]        rd_addr;

   assign base_dec = (base_ff == '0) ? LastIdx : base_ff - IW'(1);
   assign req_pt   = '{x: req_data.coord_x, y: req_data.coord_y, z: req_data.coord_z};
   assign req_up   = (req_data.action != ACT_POP_TOP);

   assign ev_used    = used_ff[eval_idx_ff];
   assign claim_push = eval_vld_ff && (act_ff == ACT_PUSH_TOP) && !done_ff && !ev_used;
   assign claim_pop  = eval_vld_ff && ((act_ff == ACT_POP_TOP) || (act_ff == ACT_POP_BOTTOM))
                       && !done_ff && ev_used;
   assign eff_used   = claim_push || (ev_used && !claim_pop);
   assign eff_pt     = claim_push ? pt_ff : rd_ff;
   assign norm       = l1_norm(eff_pt.x, eff_pt.y, eff_pt.z);
   // downward scans keep the lowest slot on ties by taking equal norms
   assign far_take   = !any_ff || (up_ff ? (norm > far_n_ff) : (norm >= far_n_ff));
   assign near_take  = !any_ff || (up_ff ? (norm < near_n_ff) : (norm <= near_n_ff));

   assign wr_en   = (cmd.load && (req_data.action == ACT_PUSH_BOTTOM)) || claim_push;
   assign wr_addr = cmd.load ? base_dec : phys(base_ff, eval_idx_ff);
   assign wr_data = cmd.load ? req_pt : pt_ff;
   assign rd_addr = phys(base_ff, idx_ff);

   assign status.scan_last = (idx_ff == (up_ff ? LastIdx : '0));
   assign status.rsp_busy  = rsp_vld_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (cmd.issue) rd_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         base_ff     <= '0;
         eval_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         eval_vld_ff <= cmd.issue;
         if (cmd.load) begin
            if (req_data.action == ACT_PUSH_BOTTOM) begin
               used_ff <= {used_ff[SLOT_COUNT-2:0], 1'b1};
               base_ff <= base_dec;
            end else if (req_data.action == ACT_CLEAR_ALL) begin
               used_ff <= '0;
            end
         end else if (claim_push || claim_pop) begin
            used_ff[eval_idx_ff] <= claim_push;
         end
         if (cmd.out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff  <= req_data.action;
         pt_ff   <= req_pt;
         up_ff   <= req_up;
         idx_ff  <= req_up ? '0 : LastIdx;
         done_ff <= 1'b0;
         drop_ff <= (req_data.action == ACT_PUSH_BOTTOM) && used_ff[LastIdx];
         any_ff  <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         if (cmd.issue) begin
            idx_ff <= up_ff ? idx_ff + IW'(1) : idx_ff - IW'(1);
         end
         if (claim_push || claim_pop) done_ff <= 1'b1;
         if (eval_vld_ff && eff_used) begin
            cnt_ff <= cnt_ff + CW'(1);
            any_ff <= 1'b1;
            if (far_take) begin
               far_n_ff   <= norm;
               far_idx_ff <= eval_idx_ff;
               far_pt_ff  <= eff_pt;
            end
            if (near_take) begin
               near_n_ff   <= norm;
               near_idx_ff <= eval_idx_ff;
               near_pt_ff  <= eff_pt;
            end
         end
      end
      if (cmd.issue) eval_idx_ff <= idx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.used_count <= 5'(cnt_ff);
         rsp_ff.dropped    <= drop_ff || ((act_ff == ACT_PUSH_TOP) && !done_ff);
         rsp_ff.far_slot   <= any_ff ? 4'(far_idx_ff) : 4'd0;
         rsp_ff.far_x      <= any_ff ? far_pt_ff.x : '0;
         rsp_ff.far_y      <= any_ff ? far_pt_ff.y : '0;
         rsp_ff.far_z      <= any_ff ? far_pt_ff.z : '0;
         rsp_ff.near_slot  <= any_ff ? 4'(near_idx_ff) : 4'd0;
         rsp_ff.near_x     <= any_ff ? near_pt_ff.x : '0;
         rsp_ff.near_y     <= any_ff ? near_pt_ff.y : '0;
         rsp_ff.near_z     <= any_ff ? near_pt_ff.z : '0;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: sv/point_slot_table_l1_search.sv
// Slot table of 3-D points with L1 search. Each request performs one table action
// (push/pop at either end, clear) and returns one response with the used count,
// a drop flag, and the lowest used slots holding the largest and smallest L1 norm.
// One request is processed at a time: a transfer in is followed by a serial scan
// over all slots through the single read port of the point memory and a drain step,
// then the response register is loaded once the response output is free, and the next
// request is taken the cycle after the response register is loaded. No clearing pass is
// needed after reset.
module point_slot_table_l1_search
   import pst_pkg::*;
#(
   parameter int SLOT_COUNT = SlotCountDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   pst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pst_dp #(
      .SLOT_COUNT (SLOT_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.used_count == 5'd0)) |->
         (rsp_data.far_slot == 4'd0) && (rsp_data.near_slot == 4'd0) &&
         (rsp_data.far_x == 16'sd0) && (rsp_data.near_z == 16'sd0))
      else $error("empty table response not zero");

   a_near_le_far: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.used_count != 5'd0)) |->
         (l1_norm(rsp_data.near_x, rsp_data.near_y, rsp_data.near_z) <=
          l1_norm(rsp_data.far_x, rsp_data.far_y, rsp_data.far_z)))
      else $error("near point farther than far point");

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import pst_pkg::*;

   localparam int SlotCount = SlotCountDefault;
   localparam int NumRandom = 1080;
   localparam int CycleLimit = 600000;
   localparam int DrainCycles = 40;
   localparam logic [2:0] ActSpareLow = 3'd6;
   localparam logic [2:0] ActSpareHigh = 3'd7;

   typedef struct {
      req_type data;
      bit      hold;
   } stim_type;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   stim_type  pend_q[$];
   rsp_type   expect_q[$];
   point_type tbl_pt[SlotCount];
   logic      tbl_used[SlotCount];
   int        errors;
   int        accepted;
   int        total_items;
   int        cycles;
   int        send_idle;
   int        recv_idle;

   point_slot_table_l1_search #(.SLOT_COUNT(SlotCount)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int coord_mag(logic signed [15:0] v);
      return (v < 0) ? -int'(v) : int'(v);
   endfunction

   function automatic int l1_of(point_type p);
      return coord_mag(p.x) + coord_mag(p.y) + coord_mag(p.z);
   endfunction

   function automatic rsp_type table_apply(req_type r);
      rsp_type   o;
      point_type p;
      int        i;
      int        hit;
      int        count;
      int        far_i;
      int        near_i;
      int        far_n;
      int        near_n;
      int        n;
      o = '0;
      p.x = r.coord_x;
      p.y = r.coord_y;
      p.z = r.coord_z;
      hit = 0;
      case (r.action)
         ACT_PUSH_TOP: begin
            o.dropped = 1'b1;
            for (i = 0; i < SlotCount; i++) begin
               if (!hit && !tbl_used[i]) begin
                  tbl_pt[i] = p;
                  tbl_used[i] = 1'b1;
                  o.dropped = 1'b0;
                  hit = 1;
               end
            end
         end
         ACT_POP_TOP: begin
            for (i = SlotCount - 1; i >= 0; i--) begin
               if (!hit && tbl_used[i]) begin
                  tbl_pt[i] = '0;
                  tbl_used[i] = 1'b0;
                  hit = 1;
               end
            end
         end
         ACT_PUSH_BOTTOM: begin
            o.dropped = tbl_used[SlotCount-1];
            for (i = SlotCount - 1; i > 0; i--) begin
               tbl_pt[i] = tbl_pt[i-1];
               tbl_used[i] = tbl_used[i-1];
            end
            tbl_pt[0] = p;
            tbl_used[0] = 1'b1;
         end
         ACT_POP_BOTTOM: begin
            for (i = 0; i < SlotCount; i++) begin
               if (!hit && tbl_used[i]) begin
                  tbl_pt[i] = '0;
                  tbl_used[i] = 1'b0;
                  hit = 1;
               end
            end
         end
         ACT_CLEAR_ALL: begin
            for (i = 0; i < SlotCount; i++) tbl_used[i] = 1'b0;
         end
         default: ;
      endcase
      count = 0;
      far_i = -1;
      near_i = -1;
      far_n = 0;
      near_n = 0;
      for (i = 0; i < SlotCount; i++) begin
         if (tbl_used[i]) begin
            count++;
            n = l1_of(tbl_pt[i]);
            if (far_i < 0 || n > far_n) begin
               far_i = i;
               far_n = n;
            end
            if (near_i < 0 || n < near_n) begin
               near_i = i;
               near_n = n;
            end
         end
      end
      o.used_count = 5'(count);
      if (far_i >= 0) begin
         o.far_slot = 4'(far_i);
         o.far_x = tbl_pt[far_i].x;
         o.far_y = tbl_pt[far_i].y;
         o.far_z = tbl_pt[far_i].z;
         o.near_slot = 4'(near_i);
         o.near_x = tbl_pt[near_i].x;
         o.near_y = tbl_pt[near_i].y;
         o.near_z = tbl_pt[near_i].z;
      end
      return o;
   endfunction

   task automatic report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      errors++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
   endtask

   task automatic add(logic [2:0] act, logic [15:0] x, logic [15:0] y, logic [15:0] z);
      stim_type s;
      s.data.action = act;
      s.data.coord_x = x;
      s.data.coord_y = y;
      s.data.coord_z = z;
      s.hold = 1'b0;
      pend_q.push_back(s);
      total_items++;
   endtask

   task automatic add_hold();
      stim_type s;
      s.data = '0;
      s.hold = 1'b1;
      pend_q.push_back(s);
   endtask

   function automatic logic [15:0] rand_coord();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) begin
         case ($urandom_range(4))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'hffff;
            3: return 16'h0001;
            default: return 16'h0000;
         endcase
      end
      if (sel <= 3) return 16'($signed($urandom_range(6)) - 3);
      return 16'($urandom);
   endfunction

   function automatic logic [2:0] rand_action(int mode);
      int r;
      r = $urandom_range(99);
      if (r < 3) return ActSpareLow + 3'($urandom_range(1));
      if (r < 5) return ACT_CLEAR_ALL;
      if (r < 8) return ACT_NONE;
      case (mode)
         0: return (r < 70) ? ACT_PUSH_TOP : (r < 88) ? ACT_PUSH_BOTTOM :
                   (r < 94) ? ACT_POP_TOP : ACT_POP_BOTTOM;
         1: return (r < 45) ? ACT_POP_TOP : (r < 80) ? ACT_POP_BOTTOM :
                   (r < 90) ? ACT_PUSH_TOP : ACT_PUSH_BOTTOM;
         default: return (r < 30) ? ACT_PUSH_TOP : (r < 55) ? ACT_PUSH_BOTTOM :
                         (r < 78) ? ACT_POP_TOP : ACT_POP_BOTTOM;
      endcase
   endfunction

   // driver: one transfer per accepted item, prediction at the transfer edge
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expect_q.push_back(table_apply(req_data));
            accepted++;
         end
         if (accepted * 3 < total_items) begin
            send_idle = 20;
            recv_idle = 61;
         end else if (accepted * 3 < total_items * 2) begin
            send_idle = 61;
            recv_idle = 20;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
         if (!req_valid || req_ready) begin
            if (pend_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pend_q[0].hold) begin
               req_valid <= 1'b0;
               if (expect_q.size() == 0) void'(pend_q.pop_front());
            end else if ($urandom_range(99) < send_idle) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data <= pend_q[0].data;
               void'(pend_q.pop_front());
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expect_q.size() == 0) begin
            report($sformatf("unexpected response %h", rsp_data));
         end else begin
            want = expect_q.pop_front();
            check_field("used_count", 16'(rsp_data.used_count), 16'(want.used_count));
            check_field("dropped", 16'(rsp_data.dropped), 16'(want.dropped));
            check_field("far_slot", 16'(rsp_data.far_slot), 16'(want.far_slot));
            check_field("far_x", rsp_data.far_x, want.far_x);
            check_field("far_y", rsp_data.far_y, want.far_y);
            check_field("far_z", rsp_data.far_z, want.far_z);
            check_field("near_slot", 16'(rsp_data.near_slot), 16'(want.near_slot));
            check_field("near_x", rsp_data.near_x, want.near_x);
            check_field("near_y", rsp_data.near_y, want.near_y);
            check_field("near_z", rsp_data.near_z, want.near_z);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int i;
      int n;
      int mode;
      errors = 0;
      accepted = 0;
      total_items = 0;
      cycles = 0;
      send_idle = 0;
      recv_idle = 0;
      for (i = 0; i < SlotCount; i++) begin
         tbl_used[i] = 1'b0;
         tbl_pt[i] = '0;
      end
      reset = 1'b1;

      // empty-table cases, spare codes
      add(ACT_NONE, 16'h1234, 16'h5678, 16'h9abc);
      add(ActSpareLow, 16'hffff, 16'hffff, 16'hffff);
      add(ActSpareHigh, 16'h0000, 16'h0000, 16'h0000);
      add(ACT_POP_TOP, 16'h0000, 16'h0000, 16'h0000);
      add(ACT_POP_BOTTOM, 16'h0000, 16'h0000, 16'h0000);
      // coordinate extremes, largest norm
      add(ACT_PUSH_TOP, 16'h8000, 16'h8000, 16'h8000);
      add(ACT_PUSH_TOP, 16'h7fff, 16'h7fff, 16'h7fff);
      add(ACT_PUSH_TOP, 16'h0000, 16'h0000, 16'h0000);
      // equal norms, lowest slot wins
      add(ACT_PUSH_TOP, 16'h0001, 16'h0000, 16'h0000);
      add(ACT_PUSH_BOTTOM, 16'h0000, 16'hffff, 16'h0000);
      add(ACT_PUSH_BOTTOM, 16'h0000, 16'h0000, 16'h0001);
      add(ACT_PUSH_BOTTOM, 16'h8000, 16'h8000, 16'h8000);
      add(ACT_POP_TOP, 16'h0000, 16'h0000, 16'h0000);
      add(ACT_POP_BOTTOM, 16'h0000, 16'h0000, 16'h0000);
      add(ACT_PUSH_TOP, 16'h5555, 16'haaaa, 16'h5555);
      add(ACT_CLEAR_ALL, 16'h0000, 16'h0000, 16'h0000);
      add(ACT_NONE, 16'h0000, 16'h0000, 16'h0000);
      // push_bottom fills past the top, then push_top into a full table
      for (i = 0; i < SlotCount + 1; i++) add(ACT_PUSH_BOTTOM, rand_coord(), rand_coord(),
                                              rand_coord());
      add(ACT_PUSH_TOP, 16'h0002, 16'h0002, 16'h0002);
      add(ACT_CLEAR_ALL, 16'h0000, 16'h0000, 16'h0000);
      add_hold();

      n = 0;
      while (n < NumRandom) begin
         mode = $urandom_range(2);
         repeat ($urandom_range(40, 5)) begin
            add(rand_action(mode), rand_coord(), rand_coord(), rand_coord());
            n++;
         end
         if (n > 400 && n < 450) add_hold();
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pend_q.size() != 0 || req_valid || expect_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (errors == 0 && expect_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
